// ===== src/mf3_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_pkg
// shared types, constants and compare helpers of the 3x3 median filter
// ----------------------------------------------------------------------------
package mf3_pkg;

    localparam int PIX_W        = 8;
    localparam int POS_W        = 11;
    localparam int CFG_W        = 12;
    localparam int APB_DW       = 32;
    localparam int APB_AW       = 3;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 32;
    localparam int MIN_DIM      = 3;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam logic [CFG_W-1:0] RST_WIDTH  = CFG_W'(640);
    localparam logic [CFG_W-1:0] RST_HEIGHT = CFG_W'(480);

    // register select, paddr bit 2 picks the register
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        t_pix lo;
        t_pix md;
        t_pix hi;
    } t_tri;

    typedef struct packed {
        t_tri c0;
        t_tri c1;
        t_tri c2;
    } t_win;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } t_meta;

    function automatic t_pix min2(input t_pix a, input t_pix b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_pix max2(input t_pix a, input t_pix b);
        return (a < b) ? b : a;
    endfunction

    function automatic t_pix med3(input t_pix a, input t_pix b, input t_pix c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    function automatic t_tri sort3(input t_pix a, input t_pix b, input t_pix c);
        t_tri r;
        r.lo = min2(min2(a, b), c);
        r.hi = max2(max2(a, b), c);
        r.md = med3(a, b, c);
        return r;
    endfunction

endpackage

// ===== src/median_filter_3x3.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_3x3
// 3x3 median filter over a raster-order stream of 8-bit grayscale pixels
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one pixel per transfer in raster order; tuser high puts
//   that pixel at row 0, column 0. the position also wraps by itself after
//   the last pixel of a frame, so frames may follow without the marker
//   m_axis carries one result per interior pixel: the median of its 3x3
//   neighbourhood with its row and column; tlast marks the last interior
//   pixel of the frame. border pixels produce no transfer
//   image_width (addr 0x0) and image_height (addr 0x4) are written over the
//   apb port while the stream is idle; values are clamped to 3..MAX
//   a result passes through the window stage, the median stage and the
//   output register before it is on m_axis
//   throughput: one pixel per clock unless m_axis stalls, set by the single read
//   and write port of the line buffer ram (one read and one write each cycle)
//   reset clears position, window, pipeline valids and loads 640x480; ram
//   contents are not cleared and no clearing pass is run
//   a stall on m_axis fills the output register, then the median stage,
//   then the window stage before s_axis tready drops
// ----------------------------------------------------------------------------
module median_filter_3x3 #(
    parameter int MAX_WIDTH  = mf3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mf3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input pixel stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [mf3_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // [7:0] pixel
    input  logic                            s_axis_tuser,   // [0] frame_start
    // filtered result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] median, [18:8] center_row, [29:19] center_col, [31:30] zero
    output logic [mf3_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                            m_axis_tlast,   // frame_last
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mf3_pkg::APB_AW-1:0]      paddr,
    input  logic [mf3_pkg::APB_DW-1:0]      pwdata,
    output logic [mf3_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);
    import mf3_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int WCMP   = (CFG_W > CW + 1) ? CFG_W : CW + 1;
    localparam int HCMP   = (CFG_W > RW + 1) ? CFG_W : RW + 1;
    localparam int LBW    = 2 * PIX_W;
    localparam int PAD_OW = M_TDATA_W - PIX_W - 2 * POS_W;

    // configuration registers
    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;

    // position of the next pixel
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    // window stage: pixel whose line buffer read is in flight
    logic          r1_valid;
    t_pix          r1_px;
    logic [CW-1:0] r1_col;
    logic          r1_emit;
    t_meta         r1_meta;

    // two previous columns, kept sorted
    t_tri r_win_a;
    t_tri r_win_b;

    logic          cfg_wr;
    logic          in_acc;
    logic          s1_adv;
    logic          med_ready;
    logic [WCMP-1:0] w_cfg;
    logic [HCMP-1:0] h_cfg;
    logic [CW-1:0] w_last;
    logic [RW-1:0] h_last;
    logic [CW-1:0] base_col;
    logic [RW-1:0] base_row;
    logic [CW-1:0] cur_col;
    logic [RW-1:0] cur_row;
    logic          cur_emit;
    t_meta         cur_meta;
    logic [LBW-1:0] lb_rd;
    t_pix          top_px;
    t_pix          mid_px;
    t_tri          new_col;
    t_win          win;
    t_pix          med_val;
    t_meta         med_meta;

    // apb: writes complete in the access phase, no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_IMAGE_WIDTH:  r_width  <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: r_height <= pwdata[CFG_W-1:0];
                default:          r_width  <= r_width;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_IMAGE_WIDTH:  prdata = APB_DW'(r_width);
            REG_IMAGE_HEIGHT: prdata = APB_DW'(r_height);
            default:          prdata = '0;
        endcase
    end

    // last column and row of the clamped geometry
    always_comb begin
        w_cfg = WCMP'(r_width);
        h_cfg = HCMP'(r_height);
        if (w_cfg < WCMP'(MIN_DIM)) begin
            w_last = CW'(MIN_DIM - 1);
        end else if (w_cfg > WCMP'(MAX_WIDTH)) begin
            w_last = CW'(MAX_WIDTH - 1);
        end else begin
            w_last = CW'(w_cfg - WCMP'(1));
        end
        if (h_cfg < HCMP'(MIN_DIM)) begin
            h_last = RW'(MIN_DIM - 1);
        end else if (h_cfg > HCMP'(MAX_HEIGHT)) begin
            h_last = RW'(MAX_HEIGHT - 1);
        end else begin
            h_last = RW'(h_cfg - HCMP'(1));
        end
    end

    // position of the incoming pixel, pulled back inside the geometry
    always_comb begin
        base_col = s_axis_tuser ? '0 : r_col;
        base_row = s_axis_tuser ? '0 : r_row;
        cur_col  = (base_col > w_last) ? w_last : base_col;
        cur_row  = (base_row > h_last) ? h_last : base_row;
        cur_emit = (cur_col >= CW'(2)) && (cur_row >= RW'(2));
        cur_meta.row  = POS_W'(cur_row - RW'(1));
        cur_meta.col  = POS_W'(cur_col - CW'(1));
        cur_meta.last = (cur_row == h_last) && (cur_col == w_last);
    end

    // non-emitting pixels leave the window stage without waiting on the median
    assign s1_adv        = r1_valid && (!r1_emit || med_ready);
    assign s_axis_tready = !r1_valid || s1_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (cur_col == w_last) begin
                r_col <= '0;
                r_row <= (cur_row == h_last) ? '0 : cur_row + RW'(1);
            end else begin
                r_col <= cur_col + CW'(1);
                r_row <= cur_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (in_acc) begin
            r1_valid <= 1'b1;
        end else if (s1_adv) begin
            r1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r1_px   <= s_axis_tdata[PIX_W-1:0];
            r1_col  <= cur_col;
            r1_emit <= cur_emit;
            r1_meta <= cur_meta;
        end
    end

    // older line in the upper byte, previous line in the lower byte
    mf3_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    (LBW)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (cur_col),
        .o_rd_data (lb_rd),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r1_col),
        .i_wr_data ({mid_px, r1_px})
    );

    assign top_px  = lb_rd[LBW-1:PIX_W];
    assign mid_px  = lb_rd[PIX_W-1:0];
    assign new_col = sort3(top_px, mid_px, r1_px);

    always_comb begin
        win.c0 = r_win_a;
        win.c1 = r_win_b;
        win.c2 = new_col;
    end

    // window shifts one column per pixel leaving the window stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_a <= '0;
            r_win_b <= '0;
        end else if (s1_adv) begin
            r_win_a <= r_win_b;
            r_win_b <= new_col;
        end
    end

    mf3_median u_median (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r1_valid && r1_emit),
        .o_ready  (med_ready),
        .i_win    (win),
        .i_meta   (r1_meta),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_median (med_val),
        .o_meta   (med_meta)
    );

    assign m_axis_tdata = {{PAD_OW{1'b0}}, med_meta.col, med_meta.row, med_val};
    assign m_axis_tlast = med_meta.last;

    // a frame marker always restarts at column 0, so the next position is column 1
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && s_axis_tuser |=> r_col == CW'(1) && r_row == '0)
        else $error("position not restarted by frame marker");

    // results only ever belong to interior pixels
    a_interior_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[PIX_W+POS_W-1:PIX_W] != '0 &&
                          m_axis_tdata[PIX_W+2*POS_W-1:PIX_W+POS_W] != '0)
        else $error("border pixel emitted");

    // input back-pressure only when the window stage holds a pixel
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r1_valid && r1_emit && !med_ready)
        else $error("input stalled without a blocked window stage");

endmodule

// ===== src/mf3_line_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_line_buf
// two line buffers in one synchronous ram, with same-entry forwarding
// ----------------------------------------------------------------------------
module mf3_line_buf #(
    parameter int DEPTH = mf3_pkg::DEF_MAX_WIDTH,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = 2 * mf3_pkg::PIX_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);
    import mf3_pkg::*;

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;
    logic [DW-1:0] r_fwd_data;
    logic          r_fwd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    // a write to the entry being read in the same cycle wins over the stale ram word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_rd_data;

endmodule

// ===== src/mf3_median.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_median
// median of nine from three sorted columns, one stage plus output register
// ----------------------------------------------------------------------------
module mf3_median (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  mf3_pkg::t_win   i_win,
    input  mf3_pkg::t_meta  i_meta,
    output logic            o_valid,
    input  logic            i_ready,
    output mf3_pkg::t_pix   o_median,
    output mf3_pkg::t_meta  o_meta
);
    import mf3_pkg::*;

    logic  r_s2_valid;
    t_win  r_s2_win;
    t_meta r_s2_meta;
    logic  r_o_valid;
    t_pix  r_o_median;
    t_meta r_o_meta;

    logic  s2_ready;
    logic  s2_adv;
    t_pix  lo_max;
    t_pix  md_med;
    t_pix  hi_min;
    t_pix  n_median;

    assign s2_ready = !r_o_valid || i_ready;
    assign s2_adv   = r_s2_valid && s2_ready;
    assign o_ready  = !r_s2_valid || s2_ready;

    // largest low, middle mid, smallest high, then the median of those three
    always_comb begin
        lo_max   = max2(max2(r_s2_win.c0.lo, r_s2_win.c1.lo), r_s2_win.c2.lo);
        md_med   = med3(r_s2_win.c0.md, r_s2_win.c1.md, r_s2_win.c2.md);
        hi_min   = min2(min2(r_s2_win.c0.hi, r_s2_win.c1.hi), r_s2_win.c2.hi);
        n_median = med3(lo_max, md_med, hi_min);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_s2_valid <= 1'b1;
            end else if (s2_adv) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_adv) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s2_win  <= i_win;
            r_s2_meta <= i_meta;
        end
        if (s2_adv) begin
            r_o_median <= n_median;
            r_o_meta   <= r_s2_meta;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_median = r_o_median;
    assign o_meta   = r_o_meta;

endmodule
